FILE: rtl/fdm_pkg.sv
// Shared widths, register codes and reset values of the feedback delay mixer.
package fdm_pkg;

  // Fixed widths of the configuration fields
  localparam int unsigned DelayBits   = 17;
  localparam int unsigned GainBits    = 16;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 32;

  // Q2.14 gains: fraction bits and the half-up rounding offset
  localparam int unsigned FracBits  = 14;
  localparam int unsigned RoundBias = 8192;

  // The delay modulo unit has two register stages
  localparam int unsigned DmodLatency = 2;
  localparam int unsigned SettleBits  = 2;

  // Reset values of the registers
  localparam logic                       ActiveReset = 1'b1;
  localparam logic signed [GainBits-1:0] DryReset    = 16'sd16384;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxBits-1:0] {
    RegActive   = 3'd0,
    RegDelay    = 3'd1,
    RegFeedback = 3'd2,
    RegWet      = 3'd3,
    RegDry      = 3'd4
  } cfg_reg_e;

endpackage

FILE: rtl/fdm_if.sv
// Channel interfaces of the feedback delay mixer: sample in, sample out, configuration.

interface fdm_in_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface fdm_out_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface fdm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fdm_pkg::CfgIdxBits-1:0]  index;
  logic [fdm_pkg::CfgDataBits-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/feedback_delay_mixer.sv
// Top level of the feedback delay mixer: sample store, mixing pipeline and registers.

// One signed sample enters per item and one mixed sample leaves per item, in order. The
// sustained rate is one item per clock cycle without output stalls or input hold-offs;
// each accepted item passes the stage one, stage two and output registers, and output
// stalls are absorbed by the pipeline registers before the input is held off. The
// rate is set by the feedback loop in stage one: the delayed sample, forwarded from the
// last store write when the entries coincide, passes through the feedback multiplier,
// rounding and saturation and is written back in the same cycle. The store is one
// single-port-write, single-port-read memory with registered read data. Input is held off
// while a configuration write is presented, and after it or reset while the delay is
// reduced modulo the store depth. Clearing the store (at reset or when active is written
// 0) resets a fill count that marks which entries hold samples; older ones read as zero.
module feedback_delay_mixer #(
  parameter int unsigned STORE_DEPTH = 131072,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fdm_in_if.sink    in_i,
  fdm_out_if.source out_o,
  fdm_cfg_if.sink   cfg_i
);

  localparam int unsigned AddrBits = $clog2(STORE_DEPTH);
  localparam int unsigned CntBits  = $clog2(STORE_DEPTH + 1);
  localparam int unsigned DB       = fdm_pkg::DelayBits;
  localparam int unsigned GB       = fdm_pkg::GainBits;
  localparam int unsigned ProdBits = SAMPLE_BITS + GB;
  localparam int unsigned SumBits  = ProdBits + 1;
  localparam int unsigned RndBits  = SumBits - fdm_pkg::FracBits;

  localparam logic signed [SAMPLE_BITS-1:0] SampleMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SampleMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Round half up after removing the gain fraction, then saturate to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
    input logic signed [SumBits-1:0] acc
  );
    logic signed [SumBits-1:0]     biased;
    logic signed [RndBits-1:0]     scaled;
    logic signed [SAMPLE_BITS-1:0] res;
    biased = acc + SumBits'(fdm_pkg::RoundBias);
    scaled = RndBits'(biased >>> fdm_pkg::FracBits);
    if (scaled > RndBits'(SampleMax)) begin
      res = SampleMax;
    end else if (scaled < RndBits'(SampleMin)) begin
      res = SampleMin;
    end else begin
      res = scaled[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

  // Configuration registers
  logic                 active_q;
  logic [DB-1:0]        delay_q;
  logic signed [GB-1:0] fb_q;
  logic signed [GB-1:0] wet_q;
  logic signed [GB-1:0] dry_q;
  logic                 cfg_acc;
  logic                 clear_store;

  logic [fdm_pkg::SettleBits-1:0] settle_q;

  // Delay reduced modulo the depth, and its complement
  logic [CntBits-1:0] lag;
  logic [CntBits-1:0] back;

  // Write position and fill count
  logic [AddrBits-1:0] wp_q;
  logic [CntBits-1:0]  fill_q;

  // Handshake and accept-stage logic
  logic                en1;
  logic                en2;
  logic                en3;
  logic                in_acc;
  logic                byp_in;
  logic                entry_ok;
  logic                mem_re;
  logic [AddrBits-1:0] rd_addr;

  // Sample store
  logic signed [SAMPLE_BITS-1:0] mem_q [STORE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rdata_q;

  // Stage one
  logic                          v1_q;
  logic                          byp1_q;
  logic                          ok1_q;
  logic signed [SAMPLE_BITS-1:0] x1_q;
  logic [AddrBits-1:0]           wa1_q;
  logic [AddrBits-1:0]           ra1_q;
  logic                          fwd_hit;
  logic signed [SAMPLE_BITS-1:0] delayed;
  logic signed [ProdBits-1:0]    p_fb;
  logic signed [ProdBits-1:0]    p_dry;
  logic signed [ProdBits-1:0]    p_wet;
  logic signed [SAMPLE_BITS-1:0] store_val;
  logic                          wr_en;

  // Last store write, for forwarding
  logic                          lw_v_q;
  logic [AddrBits-1:0]           lw_a_q;
  logic signed [SAMPLE_BITS-1:0] lw_d_q;

  // Stage two and output register
  logic                          v2_q;
  logic                          byp2_q;
  logic signed [SAMPLE_BITS-1:0] x2_q;
  logic signed [ProdBits-1:0]    pd2_q;
  logic signed [ProdBits-1:0]    pw2_q;
  logic signed [SAMPLE_BITS-1:0] mix_val;
  logic                          ov_q;
  logic signed [SAMPLE_BITS-1:0] od_q;

  // Configuration port: always ready; the user must write it only while idle, the block does not enforce this
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign clear_store = cfg_acc && (cfg_i.index == fdm_pkg::RegActive) && !cfg_i.data[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= fdm_pkg::ActiveReset;
      delay_q  <= '0;
      fb_q     <= '0;
      wet_q    <= '0;
      dry_q    <= fdm_pkg::DryReset;
    end else if (cfg_acc) begin
      unique case (fdm_pkg::cfg_reg_e'(cfg_i.index))
        fdm_pkg::RegActive:   active_q <= cfg_i.data[0];
        fdm_pkg::RegDelay:    delay_q  <= cfg_i.data[DB-1:0];
        fdm_pkg::RegFeedback: fb_q     <= cfg_i.data[GB-1:0];
        fdm_pkg::RegWet:      wet_q    <= cfg_i.data[GB-1:0];
        fdm_pkg::RegDry:      dry_q    <= cfg_i.data[GB-1:0];
        default: ;
      endcase
    end
  end

  // Hold off input until the reduced delay reflects the latest register values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= fdm_pkg::SettleBits'(fdm_pkg::DmodLatency);
    end else if (cfg_acc) begin
      settle_q <= fdm_pkg::SettleBits'(fdm_pkg::DmodLatency);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 1'b1;
    end
  end

  fdm_dmod #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dmod (
    .clk_i   (clk_i),
    .delay_i (delay_q),
    .lag_o   (lag),
    .back_o  (back)
  );

  // Stage enables: a stage moves when it is empty or the next one moves
  assign en3 = !ov_q || out_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_i.ready = en1 && (settle_q == '0) && !cfg_i.valid;
  assign in_acc     = in_i.valid && in_i.ready;

  // Accept stage: bypass decision, read address and whether the entry holds a sample
  assign byp_in   = !active_q || (delay_q == '0);
  assign rd_addr  = (CntBits'(wp_q) >= lag) ? AddrBits'(CntBits'(wp_q) - lag)
                                             : AddrBits'(CntBits'(wp_q) + back);
  assign entry_ok = (lag <= fill_q);
  assign mem_re   = in_acc && !byp_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (clear_store) begin
      fill_q <= '0;
    end else if (mem_re) begin
      wp_q <= (wp_q == AddrBits'(STORE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (fill_q != CntBits'(STORE_DEPTH)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Sample store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wa1_q] <= store_val;
    end
    if (mem_re) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Stage one registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byp1_q <= byp_in;
      ok1_q  <= entry_ok;
      x1_q   <= in_i.sample_in;
      wa1_q  <= wp_q;
      ra1_q  <= rd_addr;
    end
  end

  // Stage one: delayed sample with forwarding, products and the store value
  assign fwd_hit   = lw_v_q && (lw_a_q == ra1_q);
  assign delayed   = !ok1_q ? '0 : (fwd_hit ? lw_d_q : rdata_q);
  assign p_fb      = fb_q * delayed;
  assign p_dry     = dry_q * x1_q;
  assign p_wet     = wet_q * delayed;
  assign store_val = round_sat((SumBits'(x1_q) <<< fdm_pkg::FracBits) + SumBits'(p_fb));
  assign wr_en     = en2 && v1_q && !byp1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_v_q <= 1'b0;
    end else if (wr_en) begin
      lw_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lw_a_q <= wa1_q;
      lw_d_q <= store_val;
    end
  end

  // Stage two registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      byp2_q <= byp1_q;
      x2_q   <= x1_q;
      pd2_q  <= p_dry;
      pw2_q  <= p_wet;
    end
  end

  // Stage two: mix sum, or the input itself in bypass
  assign mix_val = byp2_q ? x2_q : round_sat(SumBits'(pd2_q) + SumBits'(pw2_q));

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en3) begin
      ov_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      od_q <= mix_val;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.sample_out = od_q;

  // The fill count never passes the depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntBits'(STORE_DEPTH))
    else $error("fill count beyond store depth");

  // Writing active to zero empties the store at once.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_store |=> (fill_q == '0))
    else $error("store not cleared after active written zero");

  // A stalled item in stage one keeps its address and sample.
  a_stage1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !en2) |=> (v1_q && $stable(wa1_q) && $stable(x1_q)))
    else $error("stage one item lost while stalled");

  // Only a full-lap delay reads the entry about to be written.
  a_addr_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_re && (lag != CntBits'(STORE_DEPTH))) |-> (rd_addr != wp_q))
    else $error("read address meets write position");

endmodule

FILE: rtl/fdm_dmod.sv
// Two-stage unit that reduces the delay register modulo the store depth.
module fdm_dmod #(
  parameter int unsigned STORE_DEPTH = 131072,
  localparam int unsigned CntBits = $clog2(STORE_DEPTH + 1)
) (
  input  logic                             clk_i,
  input  logic [fdm_pkg::DelayBits-1:0]    delay_i,
  output logic [CntBits-1:0]               lag_o,
  output logic [CntBits-1:0]               back_o
);

  localparam int unsigned DB = fdm_pkg::DelayBits;

  // Number of shifted copies of the depth that fit below the delay range
  function automatic int step_count();
    int n;
    n = 0;
    for (int i = 0; i < DB; i++) begin
      if ((longint'(STORE_DEPTH) << i) < (longint'(1) << DB)) begin
        n++;
      end
    end
    return n;
  endfunction

  localparam int NStep = step_count();
  localparam int NLow  = NStep / 2;

  logic [DB-1:0]      rem1;
  logic [DB-1:0]      rem1_q;
  logic [DB-1:0]      rem2;
  logic [CntBits-1:0] lag_d;
  logic [CntBits-1:0] lag_q;
  logic [CntBits-1:0] back_q;

  // First stage: restoring subtraction of the upper shifted copies
  always_comb begin
    rem1 = delay_i;
    for (int i = DB - 1; i >= 0; i--) begin
      if (i < NStep && i >= NLow) begin
        if (rem1 >= DB'(longint'(STORE_DEPTH) << i)) begin
          rem1 = rem1 - DB'(longint'(STORE_DEPTH) << i);
        end
      end
    end
  end

  // Second stage: the lower copies, then a zero remainder stands for a full lap
  always_comb begin
    rem2 = rem1_q;
    for (int i = DB - 1; i >= 0; i--) begin
      if (i < NLow) begin
        if (rem2 >= DB'(longint'(STORE_DEPTH) << i)) begin
          rem2 = rem2 - DB'(longint'(STORE_DEPTH) << i);
        end
      end
    end
    lag_d = (rem2 == '0) ? CntBits'(STORE_DEPTH) : CntBits'(rem2);
  end

  always_ff @(posedge clk_i) begin
    rem1_q <= rem1;
    lag_q  <= lag_d;
    back_q <= CntBits'(STORE_DEPTH) - lag_d;
  end

  assign lag_o  = lag_q;
  assign back_o = back_q;

endmodule

FILE: dv/tb.sv
// Self-checking testbench of the feedback delay mixer: directed table, then random segments.
`timescale 1ns / 100ps

module tb;
  import fdm_pkg::*;

  localparam int unsigned SampleBits   = 24;
  localparam int unsigned StoreDepth   = 131072;
  localparam int unsigned NumRegIdx    = 1 << CfgIdxBits;
  localparam int unsigned RandSegments = 12;
  localparam int unsigned SegItems     = 154;
  localparam int unsigned LongHold     = 60;
  localparam int unsigned NumRows      = 41;

  // First index that decodes to no register
  localparam logic [CfgIdxBits-1:0] RegNone = CfgIdxBits'(int'(RegDry) + 1);

  localparam logic signed [SampleBits-1:0] SampleMax = {1'b0, {(SampleBits-1){1'b1}}};
  localparam logic signed [SampleBits-1:0] SampleMin = {1'b1, {(SampleBits-1){1'b0}}};

  // Gain words as written to the port; the low GainBits carry the Q2.14 value
  localparam logic [CfgDataBits-1:0] GainOne = CfgDataBits'(1 << FracBits);
  localparam logic [CfgDataBits-1:0] GainTop = CfgDataBits'(2 ** (GainBits - 1) - 1);
  localparam logic [CfgDataBits-1:0] GainLow = ~GainTop;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [GainBits-1:0]   gain_t;

  typedef enum bit {RowWrite, RowSample} row_kind_e;

  // One line of the directed table: a register write or a sample item
  typedef struct {
    row_kind_e               kind;
    logic [CfgIdxBits-1:0]   idx;
    logic [CfgDataBits-1:0]  data;
    bit                      fixed;
    sample_t                 want;
  } row_t;

  // Result value pinned by the table for one sample item
  typedef struct {
    bit      fixed;
    sample_t want;
  } pin_t;

  logic clk;
  logic rst_n;

  fdm_in_if #(.SAMPLE_BITS(SampleBits))  in_ch ();
  fdm_out_if #(.SAMPLE_BITS(SampleBits)) out_ch ();
  fdm_cfg_if                             cfg_ch ();

  feedback_delay_mixer #(
    .STORE_DEPTH(StoreDepth),
    .SAMPLE_BITS(SampleBits)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  // Directed table: bypass after reset, forwarding at a delay of one, gain and sample
  // extremes, wide register data, an unknown index, clearing and the longest delay.
  row_t directed_rows [NumRows] = '{
    '{RowSample, '0, 32'd0, 1'b1, 24'sd0},
    '{RowSample, '0, 32'(SampleMax), 1'b1, SampleMax},
    '{RowSample, '0, 32'(SampleMin), 1'b1, SampleMin},
    '{RowSample, '0, 32'h005A_5A5A, 1'b1, 24'sh5A5A5A},
    '{RowWrite, RegDelay, 32'd1, 1'b0, '0},
    '{RowWrite, RegWet, GainOne, 1'b0, '0},
    '{RowWrite, RegFeedback, GainOne, 1'b0, '0},
    '{RowSample, '0, 32'd1000, 1'b1, 24'sd1000},
    '{RowSample, '0, 32'(SampleMax), 1'b1, SampleMax},
    '{RowSample, '0, 32'(SampleMin), 1'b0, '0},
    '{RowSample, '0, 32'd0, 1'b0, '0},
    '{RowWrite, RegDry, 32'hABCD_7FFF, 1'b0, '0},
    '{RowWrite, RegWet, GainLow, 1'b0, '0},
    '{RowWrite, RegFeedback, GainTop, 1'b0, '0},
    '{RowSample, '0, 32'(SampleMax), 1'b0, '0},
    '{RowSample, '0, 32'(SampleMin), 1'b0, '0},
    '{RowSample, '0, 32'd12345, 1'b0, '0},
    '{RowWrite, RegDelay, 32'hFFFE_0003, 1'b0, '0},
    '{RowSample, '0, 32'hFFFF_FFFF, 1'b0, '0},
    '{RowSample, '0, 32'd7, 1'b0, '0},
    '{RowSample, '0, 32'(SampleMin), 1'b0, '0},
    '{RowWrite, RegNone, 32'hFFFF_FFFF, 1'b0, '0},
    '{RowSample, '0, 32'd100, 1'b0, '0},
    '{RowWrite, RegActive, 32'hFFFF_FFFE, 1'b0, '0},
    '{RowSample, '0, 32'(SampleMin), 1'b1, SampleMin},
    '{RowSample, '0, 32'd4321, 1'b1, 24'sd4321},
    '{RowWrite, RegActive, 32'd1, 1'b0, '0},
    '{RowWrite, RegDelay, 32'h0001_FFFF, 1'b0, '0},
    '{RowWrite, RegDry, GainLow, 1'b0, '0},
    '{RowSample, '0, 32'(SampleMin), 1'b1, SampleMax},
    '{RowSample, '0, 32'(SampleMax), 1'b1, SampleMin},
    '{RowWrite, RegDelay, 32'd0, 1'b0, '0},
    '{RowSample, '0, 32'd77, 1'b1, 24'sd77},
    '{RowWrite, RegFeedback, GainLow, 1'b0, '0},
    '{RowWrite, RegWet, 32'd0, 1'b0, '0},
    '{RowWrite, RegDelay, 32'd2, 1'b0, '0},
    '{RowWrite, RegDry, GainOne, 1'b0, '0},
    '{RowSample, '0, 32'(SampleMax), 1'b0, '0},
    '{RowSample, '0, 32'(SampleMax), 1'b0, '0},
    '{RowSample, '0, 32'(SampleMin), 1'b0, '0},
    '{RowSample, '0, 32'hFFFF_FFFB, 1'b0, '0}
  };

  // Echo state mirrored by the testbench
  logic                 mix_active;
  logic [DelayBits-1:0] mix_delay;
  gain_t                mix_fb;
  gain_t                mix_wet;
  gain_t                mix_dry;
  sample_t              echo_mem [StoreDepth];
  int unsigned          wr_pos;

  sample_t     mix_expect_q [$];
  pin_t        pinned_q [$];
  int unsigned err_count;
  int unsigned items_in;
  int unsigned results_ok;
  int unsigned writes_seen;
  int unsigned echo_items;

  // Receiver control, shared with the main sequence
  int unsigned stall_pct;
  int unsigned hold_req;
  int unsigned hold_left;

  // Round half up from Q.14 and clip to the sample range.
  function automatic sample_t round_sat(longint acc);
    longint q;
    q = (acc + longint'(RoundBias)) >>> FracBits;
    if (q > longint'(SampleMax)) q = longint'(SampleMax);
    if (q < longint'(SampleMin)) q = longint'(SampleMin);
    return sample_t'(q);
  endfunction

  function automatic void echo_clear();
    foreach (echo_mem[i]) echo_mem[i] = '0;
  endfunction

  function automatic void echo_reset();
    mix_active = ActiveReset;
    mix_delay  = '0;
    mix_fb     = '0;
    mix_wet    = '0;
    mix_dry    = DryReset;
    wr_pos     = 0;
    echo_clear();
  endfunction

  // Register update; bits above each width are dropped and unknown indexes do nothing.
  function automatic void echo_write_reg(logic [CfgIdxBits-1:0] idx,
                                         logic [CfgDataBits-1:0] data);
    case (idx)
      RegActive: begin
        mix_active = data[0];
        if (!data[0]) echo_clear();
      end
      RegDelay:    mix_delay = data[DelayBits-1:0];
      RegFeedback: mix_fb = data[GainBits-1:0];
      RegWet:      mix_wet = data[GainBits-1:0];
      RegDry:      mix_dry = data[GainBits-1:0];
      default: ;
    endcase
  endfunction

  // One sample through the echo: mix the delayed sample out, feed it back into the store.
  function automatic sample_t echo_step(sample_t x);
    int unsigned rd_pos;
    longint      dl;
    longint      mixed;
    longint      fed;
    if (!mix_active || mix_delay == 0) return x;
    rd_pos = (wr_pos + StoreDepth - (mix_delay % StoreDepth)) % StoreDepth;
    dl = longint'(echo_mem[rd_pos]);
    mixed = longint'(mix_dry) * longint'(x) + longint'(mix_wet) * dl;
    fed = longint'(x) * (longint'(1) << FracBits) + longint'(mix_fb) * dl;
    echo_mem[wr_pos] = round_sat(fed);
    wr_pos = (wr_pos + 1) % StoreDepth;
    return round_sat(mixed);
  endfunction

  task automatic report_err(string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Limit on the whole run
  initial begin
    #2_000_000;
    $display("Timed out with %0d results still awaited", mix_expect_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stalls, and a long hold-off counted here when one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watch every handshake: register writes and accepted items feed the predictor,
  // and each result is compared with the oldest expectation.
  always @(posedge clk) begin
    sample_t want;
    pin_t    pin;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        echo_write_reg(cfg_ch.index, cfg_ch.data);
        writes_seen++;
      end
      if (in_ch.valid && in_ch.ready) begin
        if (mix_active && mix_delay != 0) echo_items++;
        want = echo_step(in_ch.sample_in);
        if (pinned_q.size() != 0) begin
          pin = pinned_q.pop_front();
          if (pin.fixed) want = pin.want;
        end
        mix_expect_q.push_back(want);
        items_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (mix_expect_q.size() == 0) begin
          report_err($sformatf("result %0d arrived with no item waiting", results_ok));
        end else begin
          want = mix_expect_q.pop_front();
          if (out_ch.sample_out !== want)
            report_err($sformatf("result %0d: sample_out %0d, expected %0d",
                                 results_ok, out_ch.sample_out, want));
          results_ok++;
        end
      end
    end
  end

  // Wait on the clock until every expected result has come, checking only after each edge.
  task automatic wait_drained();
    do @(posedge clk); while (mix_expect_q.size() != 0);
  endtask

  // A register write is only made with the block empty.
  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
    in_ch.valid <= 1'b0;
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Offer one item after a random gap; returns at the edge where it is accepted.
  task automatic send_sample(sample_t x, bit fixed, sample_t want, int unsigned gap);
    pin_t pin;
    if (gap != 0 && $urandom_range(0, 99) < gap) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap);
    end
    pin.fixed = fixed;
    pin.want  = want;
    pinned_q.push_back(pin);
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= x;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Gains lean towards the extremes, unity and zero; upper data bits are noise.
  function automatic logic [CfgDataBits-1:0] pick_gain();
    logic [CfgDataBits-1:0] d;
    d = $urandom();
    case ($urandom_range(0, 7))
      0: d[GainBits-1:0] = GainLow[GainBits-1:0];
      1: d[GainBits-1:0] = GainTop[GainBits-1:0];
      2: d[GainBits-1:0] = GainOne[GainBits-1:0];
      3: d[GainBits-1:0] = '0;
      default: ;
    endcase
    return d;
  endfunction

  // Mostly short delays so echoes come back within a segment; sometimes the longest.
  function automatic logic [CfgDataBits-1:0] pick_delay();
    logic [CfgDataBits-1:0] d;
    d = $urandom();
    case ($urandom_range(0, 9))
      0: d[DelayBits-1:0] = '1;
      1: d[DelayBits-1:0] = DelayBits'(1);
      2: d[DelayBits-1:0] = DelayBits'(2);
      7: d[DelayBits-1:0] = DelayBits'($urandom_range(17, 400));
      8: ;
      9: d[DelayBits-1:0] = '0;
      default: d[DelayBits-1:0] = DelayBits'($urandom_range(1, 16));
    endcase
    return d;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return SampleMax;
      1: return SampleMin;
      2: return '0;
      3, 4: return sample_t'(int'($urandom_range(0, 2000)) - 1000);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // Main sequence
  initial begin
    int unsigned            gap_pct;
    logic [CfgDataBits-1:0] d;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    rst_n           = 1'b0;
    stall_pct       = 0;
    hold_req        = 0;
    hold_left       = 0;
    err_count       = 0;
    items_in        = 0;
    results_ok      = 0;
    writes_seen     = 0;
    echo_items      = 0;
    echo_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, no idling on either side
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == RowWrite)
        write_reg(directed_rows[r].idx, directed_rows[r].data);
      else
        send_sample(sample_t'(directed_rows[r].data), directed_rows[r].fixed,
                    directed_rows[r].want, 0);
    end

    // Random segments: a fresh setting each, cycling through the idling patterns
    for (int seg = 0; seg < RandSegments; seg++) begin
      case (seg % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 57; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 57; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      if (seg % 3 == 1) begin
        d = $urandom();
        d[0] = 1'b0;
        write_reg(RegActive, d);
      end
      d = $urandom();
      d[0] = (seg % 5 != 4);
      write_reg(RegActive, d);
      write_reg(RegDelay, pick_delay());
      write_reg(RegFeedback, pick_gain());
      write_reg(RegWet, pick_gain());
      write_reg(RegDry, pick_gain());
      if (seg % 4 == 3)
        write_reg(CfgIdxBits'($urandom_range(int'(RegNone), NumRegIdx - 1)), $urandom());
      for (int n = 0; n < SegItems; n++) begin
        // Long receiver hold-off while items keep coming, so the input backs up
        if (seg % 8 == 0 && n == SegItems / 2) hold_req = LongHold;
        // Sender pause until the block has emptied
        if (seg == 5 && n == SegItems / 2) begin
          in_ch.valid <= 1'b0;
          wait_drained();
        end
        send_sample(pick_sample(), 1'b0, '0, gap_pct);
      end
    end

    // Drain and let the pipeline settle
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Covered %0d items (%0d through the echo path) and %0d register writes,",
             items_in, echo_items, writes_seen);
    $display("with %0d results compared under four idling patterns.", results_ok);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
